// ===== rtl/i128gcd_pkg.sv =====
`default_nettype none

package i128gcd_pkg;

  // Widths of the stream fields, fixed by the item format.
  localparam int FIELD_BITS = 64;
  localparam int FULL_BITS  = 2 * FIELD_BITS;
  localparam int IN_BITS    = 4 * FIELD_BITS;
  localparam int OUT_BITS   = 136;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;     // capture both operands from the input item
    logic start_step;  // set up one remainder for the current pair
    logic div_step;    // one shift-subtract step of the remainder
    logic update;      // a <= b, b <= signed remainder
    logic load_out;    // copy the current a and flag to the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic b_zero;      // divisor is zero, Euclid is finished
    logic special;     // most negative value by minus one
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/i128gcd_ctrl.sv =====
`default_nettype none

module i128gcd_ctrl
  import i128gcd_pkg::*;
#(
  parameter int WORD_BITS = 128
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam int CW = $clog2(WORD_BITS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic          slot_free;

  assign in_ready  = (state == ST_IDLE);
  assign slot_free = !out_valid || out_ready;

  // Next state, bit counter and commands.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.b_zero) begin
          state_next = ST_FINISH;
        end else begin
          cmd.start_step = 1'b1;
          cnt_next       = CW'(WORD_BITS - 1);
          state_next     = sts.special ? ST_UPDATE : ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = ST_UPDATE;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_CHECK;
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State, counter and output valid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/i128gcd_dp.sv =====
`default_nettype none

module i128gcd_dp
  import i128gcd_pkg::*;
#(
  parameter int WORD_BITS = 128
) (
  input  wire logic                 clk,
  input  wire logic [FULL_BITS-1:0] first_in,
  input  wire logic [FULL_BITS-1:0] second_in,
  input  wire cmd_t                 cmd,
  output sts_t                      sts,
  output logic [FULL_BITS-1:0]      result,
  output logic                      result_flag
);

  localparam int W = WORD_BITS;

  logic [W-1:0] a;
  logic [W-1:0] b;
  logic [W-1:0] num;
  logic [W-1:0] den;
  logic [W-1:0] rem;
  logic         negate;
  logic         flag;
  logic [W-1:0] mag_a;
  logic [W-1:0] mag_b;
  logic [W-1:0] rem_shift;
  logic [W:0]   rem_diff;
  logic [W-1:0] min_val;

  assign min_val = {1'b1, {(W-1){1'b0}}};

  // Status toward the controller.
  assign sts.b_zero  = (b == '0);
  assign sts.special = (a == min_val) && (b == '1);

  // Magnitudes; the most negative value maps to 2^(W-1), which still fits.
  assign mag_a = a[W-1] ? (~a + 1'b1) : a;
  assign mag_b = b[W-1] ? (~b + 1'b1) : b;

  // One restoring step: the partial remainder stays below the divisor,
  // so its top bit is free for the shift.
  assign rem_shift = {rem[W-2:0], num[W-1]};
  assign rem_diff  = {1'b0, rem_shift} - {1'b0, den};

  // Operand pair, divider registers and flag.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      a    <= first_in[W-1:0];
      b    <= second_in[W-1:0];
      flag <= 1'b0;
    end
    if (cmd.start_step) begin
      num    <= mag_a;
      den    <= mag_b;
      rem    <= '0;
      negate <= a[W-1];
      if (sts.special) begin
        flag <= 1'b1;
      end
    end
    if (cmd.div_step) begin
      num <= {num[W-2:0], 1'b0};
      rem <= rem_diff[W] ? rem_shift : rem_diff[W-1:0];
    end
    if (cmd.update) begin
      a <= b;
      b <= negate ? (~rem + 1'b1) : rem;
    end
  end

  // Output register, sign-extended to the full 128 bits.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result      <= FULL_BITS'($signed(a));
      result_flag <= flag;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/int128_euclid_gcd_top.sv =====
`default_nettype none

// Signed GCD of two 128-bit integers by Euclid's algorithm with truncated
// remainder: (a, b) <- (b, a rem b) until b is zero, and the last a is
// returned, so the result keeps the sign that the remainders give it and is
// a itself when b starts at zero. With WORD_BITS below 128 each operand is
// the low WORD_BITS bits of its input, sign-extended, and the result is
// sign-extended to 128 bits. The remainder of the most negative value by
// minus one is taken as zero and sets overflow_seen. One item is worked on
// at a time; a finished result waits in the output register while the next
// item is taken. Each Euclid step is one check, WORD_BITS shift-subtract
// steps of the bit-serial remainder unit and one update; the overflow case
// skips the shift-subtract steps. The step count is data dependent, at most
// about 1.44 * WORD_BITS + 2 (about 185 steps for 128 bits); typical
// operands take a few dozen steps.

module int128_euclid_gcd_top
  import i128gcd_pkg::*;
#(
  parameter int WORD_BITS = 128
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // first_high [63:0], first_low [127:64], second_high [191:128],
  // second_low [255:192]
  input  wire logic [IN_BITS-1:0]  s_tdata,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // divisor_high [63:0], divisor_low [127:64], overflow_seen [128],
  // zero fill [135:129]
  output logic [OUT_BITS-1:0]      m_tdata
);

  cmd_t                 cmd;
  sts_t                 sts;
  logic [FULL_BITS-1:0] first_in;
  logic [FULL_BITS-1:0] second_in;
  logic [FULL_BITS-1:0] result;
  logic                 result_flag;

  // Reassemble the operands as high half over low half.
  assign first_in  = {s_tdata[FIELD_BITS-1:0], s_tdata[2*FIELD_BITS-1:FIELD_BITS]};
  assign second_in = {s_tdata[3*FIELD_BITS-1:2*FIELD_BITS],
                      s_tdata[4*FIELD_BITS-1:3*FIELD_BITS]};

  i128gcd_ctrl #(
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  i128gcd_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk         (clk),
    .first_in    (first_in),
    .second_in   (second_in),
    .cmd         (cmd),
    .sts         (sts),
    .result      (result),
    .result_flag (result_flag)
  );

  // Pack the result item.
  assign m_tdata = {{(OUT_BITS - FULL_BITS - 1){1'b0}}, result_flag,
                    result[FIELD_BITS-1:0], result[FULL_BITS-1:FIELD_BITS]};

endmodule

`default_nettype wire

// ===== rtl/i128gcd_chk.sv =====
`default_nettype none

module i128gcd_chk
  import i128gcd_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_tvalid,
  input wire logic                s_tready,
  input wire logic                m_tvalid,
  input wire logic                m_tready,
  input wire logic [OUT_BITS-1:0] m_tdata
);

  // A result that is not taken holds its value.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item changed while stalled");

  // One item at a time: the block is busy right after it takes an item.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken twice in a row");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A new result never appears while the block stands idle and ready for input.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !s_tready || $past(s_tready) == 1'b0)
    else $error("result appeared while the block stood idle");

endmodule

bind int128_euclid_gcd_top i128gcd_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i128gcd_pkg::*;

  localparam int WORD_BITS = 128;
  localparam int RANDOM_PAIRS = 450;
  // Limit on idle time; it allows the longest legal Euclid run several times over.
  localparam int IDLE_LIMIT = 100000;
  // Extra wait after the last result, sized from the remainder step length.
  localparam int DRAIN_CYCLES = 2 * (WORD_BITS + 2) + 3;

  // Input item, first field in the lowest bits.
  typedef struct packed {
    logic [FIELD_BITS-1:0] second_low;
    logic [FIELD_BITS-1:0] second_high;
    logic [FIELD_BITS-1:0] first_low;
    logic [FIELD_BITS-1:0] first_high;
  } operands_t;

  // Result item, first field in the lowest bits.
  typedef struct packed {
    logic [OUT_BITS-FULL_BITS-2:0] fill;
    logic                          overflow_seen;
    logic [FIELD_BITS-1:0]         divisor_low;
    logic [FIELD_BITS-1:0]         divisor_high;
  } gcd_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  wire logic           s_tready;
  logic [IN_BITS-1:0]  s_tdata = '0;
  wire logic           m_tvalid;
  logic                m_tready = 1'b0;
  wire logic [OUT_BITS-1:0] m_tdata;

  operands_t   operand_q[$];
  gcd_result_t gcd_q[$];
  int          pairs_total = 0;
  int          pairs_taken = 0;
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          ready_hold = 0;

  int128_euclid_gcd_top #(
    .WORD_BITS(WORD_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #4 clk = ~clk;

  // Low WORD_BITS bits of a word, sign-extended to 128 bits.
  function automatic logic [FULL_BITS-1:0] narrow_word(logic [FULL_BITS-1:0] v);
    logic signed [FULL_BITS-1:0] s;
    s = v << (FULL_BITS - WORD_BITS);
    s = s >>> (FULL_BITS - WORD_BITS);
    return s;
  endfunction

  // Euclid with truncated remainder; the most negative value by minus one
  // gives remainder zero and raises the overflow flag.
  function automatic gcd_result_t predict_gcd(operands_t op);
    logic [FULL_BITS-1:0] a, b, r, mag_a, mag_b, min_word;
    logic                 overflow;
    gcd_result_t          res;
    a = narrow_word({op.first_high, op.first_low});
    b = narrow_word({op.second_high, op.second_low});
    min_word = narrow_word(128'd1 << (WORD_BITS - 1));
    overflow = 1'b0;
    while (b != '0) begin
      if (a == min_word && b == '1) begin
        overflow = 1'b1;
        r = '0;
      end else begin
        mag_a = a[FULL_BITS-1] ? -a : a;
        mag_b = b[FULL_BITS-1] ? -b : b;
        r = mag_a % mag_b;
        if (a[FULL_BITS-1]) r = -r;
      end
      a = b;
      b = r;
    end
    res = '0;
    res.divisor_high = a[FULL_BITS-1:FIELD_BITS];
    res.divisor_low = a[FIELD_BITS-1:0];
    res.overflow_seen = overflow;
    return res;
  endfunction

  // Random word with a magnitude of at most mag bits and a random sign.
  function automatic logic [FULL_BITS-1:0] rand_word(int unsigned mag);
    logic [FULL_BITS-1:0] v;
    v = {$urandom, $urandom, $urandom, $urandom};
    if (mag < FULL_BITS) v = v & ((128'd1 << mag) - 1);
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  task automatic add_pair(logic [FULL_BITS-1:0] a, logic [FULL_BITS-1:0] b);
    operands_t op;
    op.first_high = a[FULL_BITS-1:FIELD_BITS];
    op.first_low = a[FIELD_BITS-1:0];
    op.second_high = b[FULL_BITS-1:FIELD_BITS];
    op.second_low = b[FIELD_BITS-1:0];
    operand_q.push_back(op);
  endtask

  // Driver: sends pending items in bursts with random gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        gcd_q.push_back(predict_gcd(operands_t'(s_tdata)));
        pairs_taken <= pairs_taken + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (operand_q.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata <= operand_q.pop_front();
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 12);
            if ($urandom_range(0, 3) == 0)
              gap_left <= 0;
            else if ($urandom_range(0, 9) == 0)
              gap_left <= $urandom_range(100, 3000);
            else
              gap_left <= $urandom_range(1, 30);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result against the oldest expectation and stalls
  // the output on a pattern of its own.
  always @(posedge clk) begin : monitor
    gcd_result_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
      ready_hold <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = gcd_result_t'(m_tdata);
        if (gcd_q.size() == 0) begin
          $display("%t unexpected result: expected none, actual %h", $realtime, m_tdata);
          mismatches++;
        end else begin
          want = gcd_q.pop_front();
          if (got.divisor_high !== want.divisor_high) begin
            $display("%t divisor_high: expected %h, actual %h",
                     $realtime, want.divisor_high, got.divisor_high);
            mismatches++;
          end
          if (got.divisor_low !== want.divisor_low) begin
            $display("%t divisor_low: expected %h, actual %h",
                     $realtime, want.divisor_low, got.divisor_low);
            mismatches++;
          end
          if (got.overflow_seen !== want.overflow_seen) begin
            $display("%t overflow_seen: expected %b, actual %b",
                     $realtime, want.overflow_seen, got.overflow_seen);
            mismatches++;
          end
        end
      end
      if (ready_hold > 0) begin
        ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 2) != 0) begin
        m_tready <= 1'b1;
        ready_hold <= $urandom_range(0, 60);
      end else begin
        m_tready <= 1'b0;
        ready_hold <= $urandom_range(0, 200);
      end
    end
  end

  // Count cycles in which no item moves on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    logic [FULL_BITS-1:0] min_word, max_word, fib_lo, fib_hi, fib_next, common;
    int unsigned          kind;
    int                   i;
    logic                 timed_out;

    min_word = narrow_word(128'd1 << (WORD_BITS - 1));
    max_word = min_word - 1;

    // Directed pairs: zeros, extremes, signs, the overflow case directly
    // and in the middle of a run, and the longest Fibonacci run.
    add_pair('0, '0);
    add_pair(min_word, '0);
    add_pair(max_word, '0);
    add_pair('0, -128'd5);
    add_pair(min_word, '1);
    add_pair('1, min_word);
    add_pair(min_word, 128'd1);
    add_pair(max_word, min_word);
    add_pair(min_word, min_word);
    add_pair(max_word, max_word);
    add_pair('1, '1);
    add_pair(-128'd12, 128'd18);
    add_pair(128'd12, -128'd18);
    add_pair(-128'd12, -128'd18);
    add_pair({64{2'b01}}, {64{2'b10}});
    add_pair({64{2'b10}}, 128'd3);
    add_pair(128'd7, 128'd7 << 100);
    fib_lo = 128'd1;
    fib_hi = 128'd2;
    while (fib_hi + fib_lo <= max_word) begin
      fib_next = fib_hi + fib_lo;
      fib_lo = fib_hi;
      fib_hi = fib_next;
    end
    add_pair(fib_hi, fib_lo);
    add_pair(-fib_hi, fib_lo);

    // Random pairs: mostly small magnitudes to keep runs short, some with
    // a large common factor, a few full-width, and the special cases.
    for (i = 0; i < RANDOM_PAIRS; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 4) begin
        add_pair(rand_word(128), rand_word(128));
      end else if (kind < 18) begin
        common = rand_word($urandom_range(1, 100));
        add_pair(common * rand_word($urandom_range(1, 16)),
                 common * rand_word($urandom_range(1, 16)));
      end else if (kind < 28) begin
        common = rand_word($urandom_range(1, 128));
        case ($urandom_range(0, 5))
          0: add_pair(common, '0);
          1: add_pair('0, common);
          2: add_pair(min_word, '1);
          3: add_pair(common, common);
          4: add_pair('1, min_word);
          default: add_pair(common, rand_word(1));
        endcase
      end else begin
        add_pair(rand_word($urandom_range(1, 24)), rand_word($urandom_range(1, 24)));
      end
    end
    pairs_total = operand_q.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Wait for every item to be taken and every result to come back.
    timed_out = 1'b0;
    while (!(pairs_taken == pairs_total && gcd_q.size() == 0) && !timed_out) begin
      @(negedge clk);
      if (idle_cycles >= IDLE_LIMIT) timed_out = 1'b1;
    end
    if (!timed_out) repeat (DRAIN_CYCLES) @(negedge clk);

    if (!timed_out && mismatches == 0 && gcd_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/i128gcd_pkg.sv
rtl/i128gcd_ctrl.sv
rtl/i128gcd_dp.sv
rtl/int128_euclid_gcd_top.sv
rtl/i128gcd_chk.sv
tb/tb.sv
